@@ hdl/bba_pkg.sv @@
// bba_pkg: shared types and constants of the bitmap block allocator.
// Field widths, request kinds, config register indexes, controller and status types.
// No dependencies.
package bba_pkg;

	// field widths
	localparam int BLK_W      = 12;
	localparam int CNT_W      = 13;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// map word geometry: 32 used bits per memory row
	localparam int BIT_W     = 5;
	localparam int WORD_BITS = 1 << BIT_W;

	// default volume size
	localparam int MAX_BLOCKS_DEF = 4096;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_LOAD  = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RMW,
		ST_COMMIT
	} bba_state_t;

	// controller to datapath
	typedef struct packed {
		logic start;   // request transfer, latch it
		logic scan;    // read next map word of the allocate scan
		logic rmw_rd;  // read the map word of the request block
		logic commit;  // write map, update counter, load result
	} bba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;   // scan range is empty
		logic s1_vld;  // read data valid this cycle
		logic hit;     // read word holds a free block in range
		logic last;    // read word is the last one of the range
	} bba_sts_t;

endpackage

@@ hdl/bba_if.sv @@
// bba_if: valid/ready channel interfaces of the bitmap block allocator.
// Request, result and config write channels. Depends on bba_pkg.
interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::KIND_W-1:0]  kind;
	logic [bba_pkg::BLK_W-1:0]   block_number;

	modport source (output valid, kind, block_number, input ready);
	modport sink   (input valid, kind, block_number, output ready);
endinterface

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::BLK_W-1:0]   granted_block;
	logic                        out_of_space;
	logic [bba_pkg::CNT_W-1:0]   free_total;

	modport source (output valid, granted_block, out_of_space, free_total, input ready);
	modport sink   (input valid, granted_block, out_of_space, free_total, output ready);
endinterface

interface bba_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bba_pkg::CFG_IDX_W-1:0]   index;
	logic [bba_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/bitmap_block_allocator_unit.sv @@
// bitmap_block_allocator_unit: top level of the first-fit bitmap block allocator.
// Joins bba_ctrl and bba_datapath to the channels. Depends on bba_pkg, bba_if.
//
//   channel  role    transfer carries
//   -------  ------  -----------------------------------------------
//   req      sink    kind, block_number
//   rsp      source  granted_block, out_of_space, free_total
//   cfg      sink    index, data (always ready)
//
// One request at a time. Allocate scans then commits; the scan reads one 32-bit map
// row a cycle. Free and mark-used read the request's row and write it back at commit
// (read-modify-write); an unused kind or an empty allocate goes straight to commit.
// Reset clears control state and the row valid bits; no clearing pass is needed.
// A stalled result holds its register; the next request is taken meanwhile
// and waits at commit until the result register frees.
module bitmap_block_allocator_unit #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	bba_req_if.sink  req,
	bba_rsp_if.source rsp,
	bba_cfg_if.sink  cfg
);

	bba_pkg::bba_cmd_t cmd;
	bba_pkg::bba_sts_t sts;
	logic              cfg_we;

	// config writes are taken in any cycle
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid & cfg.ready;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_kind   (req.kind),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_kind      (req.kind),
		.req_block     (req.block_number),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.granted_block (rsp.granted_block),
		.out_of_space  (rsp.out_of_space),
		.free_total    (rsp.free_total)
	);

endmodule

@@ hdl/bba_ctrl.sv @@
// bba_ctrl: controller state machine of the allocator.
// Sequences scan, read-modify-write and commit; owns result valid. Depends on bba_pkg.
module bba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bba_pkg::KIND_W-1:0]  in_kind,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  bba_pkg::bba_sts_t           sts,
	output bba_pkg::bba_cmd_t           cmd
);

	bba_pkg::bba_state_t state_q, state_nxt;
	logic                out_valid_q;
	logic                out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_free  = !out_valid_q || out_ready;
		case (state_q)
			bba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (in_kind == bba_pkg::KIND_ALLOC) begin
						state_nxt = sts.empty ? bba_pkg::ST_COMMIT : bba_pkg::ST_SCAN;
					end else if (in_kind inside {bba_pkg::KIND_FREE, bba_pkg::KIND_MARK}) begin
						state_nxt = bba_pkg::ST_RMW;
					end else begin
						state_nxt = bba_pkg::ST_COMMIT;
					end
				end
			end
			bba_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.s1_vld && (sts.hit || sts.last)) begin
					state_nxt = bba_pkg::ST_COMMIT;
				end
			end
			bba_pkg::ST_RMW: begin
				cmd.rmw_rd = 1'b1;
				state_nxt  = bba_pkg::ST_COMMIT;
			end
			bba_pkg::ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = bba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bba_pkg::ST_IDLE;
			end
		endcase
	end

	// result valid: set on commit, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a commit always presents a result in the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result");

	// read data arrives every scan cycle after the first
	a_scan_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::ST_SCAN && $past(state_q) == bba_pkg::ST_SCAN) |-> sts.s1_vld)
		else $error("scan read data missing");

	// an accepted request always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != bba_pkg::ST_IDLE)
		else $error("request accepted but controller stayed idle");

endmodule

@@ hdl/bba_datapath.sv @@
// bba_datapath: used-map memory, scan evaluation, config registers and free counter.
// Driven by bba_ctrl commands. Depends on bba_pkg.
module bba_datapath #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bba_pkg::bba_cmd_t               cmd,
	output bba_pkg::bba_sts_t               sts,
	input  logic [bba_pkg::KIND_W-1:0]      req_kind,
	input  logic [bba_pkg::BLK_W-1:0]       req_block,
	input  logic                            cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [bba_pkg::BLK_W-1:0]       granted_block,
	output logic                            out_of_space,
	output logic [bba_pkg::CNT_W-1:0]       free_total
);

	localparam int BW        = bba_pkg::BIT_W;
	localparam int WB        = bba_pkg::WORD_BITS;
	localparam int BLKW      = bba_pkg::BLK_W;
	localparam int CW        = bba_pkg::CNT_W;
	localparam int MAP_LIMIT = (MAX_BLOCKS < (1 << BLKW)) ? MAX_BLOCKS : (1 << BLKW);
	localparam int CAP_I     = (MAX_BLOCKS < (1 << CW) - 1) ? MAX_BLOCKS : (1 << CW) - 1;
	localparam int MAP_WORDS = (MAP_LIMIT + WB - 1) / WB;
	localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WIDX      = BLKW - BW;   // word index bits of a block number
	localparam int EW        = CW - BW;     // word index bits of a scan bound

	localparam logic [CW-1:0] MAP_LIMIT_C = CW'(MAP_LIMIT);
	localparam logic [CW-1:0] COUNT_CAP_C = CW'(CAP_I);

	// config registers and counter
	logic [BLKW-1:0] first_q;
	logic [CW-1:0]   bcount_q;
	logic [CW-1:0]   free_q;

	// latched request
	logic [bba_pkg::KIND_W-1:0] kind_q;
	logic [BLKW-1:0]            blk_q;

	// map memory and row valid bits
	logic [WB-1:0]        mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] row_vld_q;
	logic [WB-1:0]        rdata_s1;
	logic                 rvld_s1;
	logic                 s1_vld_q;
	logic [WAW-1:0]       word_s1;

	// scan state
	logic [WAW-1:0] ptr_q;
	logic           hit_q;
	logic [WAW-1:0] hit_word_q;
	logic [WB-1:0]  hit_data_q;
	logic [BLKW-1:0] gblk_q;

	// result registers
	logic [BLKW-1:0] res_gblk_q;
	logic            res_oos_q;
	logic [CW-1:0]   res_free_q;

	// combinational
	logic [CW-1:0]   scan_end;
	logic [WAW-1:0]  blk_word;
	logic            rd_en;
	logic [WAW-1:0]  rd_addr;
	logic [WB-1:0]   word_eff;
	logic [EW-1:0]   word_x;
	logic [WB-1:0]   lo_mask;
	logic [WB-1:0]   hi_mask;
	logic [WB-1:0]   avail;
	logic [BW-1:0]   pick;
	logic [CW-1:0]   next_base;
	logic [WB-1:0]   blk_mask;
	logic            free_ok;
	logic            mark_ok;
	logic            wr_en;
	logic            mem_we;
	logic [WAW-1:0]  wr_addr;
	logic [WB-1:0]   wr_data;
	logic [CW-1:0]   cnt_nxt;
	logic [BLKW-1:0] g_nxt;
	logic            oos_nxt;

	// scan range and read port select
	assign scan_end = (bcount_q < MAP_LIMIT_C) ? bcount_q : MAP_LIMIT_C;
	assign blk_word = blk_q[BW +: WAW];
	assign rd_en    = cmd.scan | cmd.rmw_rd;
	assign rd_addr  = cmd.scan ? ptr_q : blk_word;

	// evaluate the word read last cycle
	assign word_eff  = rvld_s1 ? rdata_s1 : '0;
	assign word_x    = EW'(word_s1);
	assign lo_mask   = (word_x == EW'(first_q[BLKW-1:BW])) ?
	                   ({WB{1'b1}} << first_q[BW-1:0]) : {WB{1'b1}};
	assign hi_mask   = (word_x == scan_end[CW-1:BW]) ?
	                   ~({WB{1'b1}} << scan_end[BW-1:0]) : {WB{1'b1}};
	assign avail     = ~word_eff & lo_mask & hi_mask;
	assign next_base = {word_x + EW'(1), BW'(0)};

	// lowest free bit of the word
	always_comb begin
		pick = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pick = BW'(i);
			end
		end
	end

	assign sts.empty  = {1'b0, first_q} >= scan_end;
	assign sts.s1_vld = s1_vld_q;
	assign sts.hit    = |avail;
	assign sts.last   = next_base >= scan_end;

	// commit decode
	assign blk_mask = WB'(1) << blk_q[BW-1:0];
	assign free_ok  = (blk_q != '0) && ({1'b0, blk_q} < bcount_q) &&
	                  ({1'b0, blk_q} < MAP_LIMIT_C);
	assign mark_ok  = {1'b0, blk_q} < MAP_LIMIT_C;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = blk_word;
		wr_data = word_eff;
		cnt_nxt = free_q;
		g_nxt   = '0;
		oos_nxt = 1'b0;
		case (kind_q)
			bba_pkg::KIND_ALLOC: begin
				if (hit_q) begin
					wr_en   = 1'b1;
					wr_addr = hit_word_q;
					wr_data = hit_data_q;
					g_nxt   = gblk_q;
					cnt_nxt = (free_q != '0) ? free_q - CW'(1) : free_q;
				end else begin
					oos_nxt = 1'b1;
				end
			end
			bba_pkg::KIND_FREE: begin
				if (free_ok) begin
					wr_en   = 1'b1;
					wr_data = word_eff & ~blk_mask;
					cnt_nxt = (free_q < COUNT_CAP_C) ? free_q + CW'(1) : free_q;
				end
			end
			bba_pkg::KIND_MARK: begin
				if (mark_ok) begin
					wr_en   = 1'b1;
					wr_data = word_eff | blk_mask;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we = cmd.commit & wr_en;

	// map memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			rvld_s1  <= row_vld_q[rd_addr];
			word_s1  <= rd_addr;
		end
	end

	// row valid bits: an unwritten row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			s1_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			s1_vld_q <= rd_en;
		end
	end

	// request latch, scan pointer and hit capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			ptr_q <= '0;
		end else if (cmd.start) begin
			hit_q <= 1'b0;
			ptr_q <= first_q[BW +: WAW];
		end else if (cmd.scan) begin
			ptr_q <= ptr_q + WAW'(1);
			if (s1_vld_q && sts.hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= req_kind;
			blk_q  <= req_block;
		end
		if (cmd.scan && s1_vld_q && sts.hit) begin
			hit_word_q <= word_s1;
			hit_data_q <= word_eff | (WB'(1) << pick);
			gblk_q     <= {WIDX'(word_s1), pick};
		end
	end

	// config registers and free counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= BLKW'(1);
			bcount_q <= CW'(1 << BLKW);
			free_q   <= '0;
		end else begin
			if (cfg_we && cfg_index == bba_pkg::CFG_FIRST_DATA) begin
				first_q <= cfg_data[BLKW-1:0];
			end
			if (cfg_we && cfg_index == bba_pkg::CFG_BLOCK_CNT) begin
				bcount_q <= cfg_data[CW-1:0];
			end
			if (cfg_we && cfg_index == bba_pkg::CFG_FREE_LOAD) begin
				free_q <= (cfg_data[CW-1:0] > COUNT_CAP_C) ? COUNT_CAP_C : cfg_data[CW-1:0];
			end else if (cmd.commit) begin
				free_q <= cnt_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_gblk_q <= g_nxt;
			res_oos_q  <= oos_nxt;
			res_free_q <= cnt_nxt;
		end
	end

	assign granted_block = res_gblk_q;
	assign out_of_space  = res_oos_q;
	assign free_total    = res_free_q;

	// counter never passes its ceiling
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= COUNT_CAP_C)
		else $error("free counter above ceiling");

	// a granted block lies inside the scan range
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && kind_q == bba_pkg::KIND_ALLOC && hit_q) |->
		({1'b0, gblk_q} >= {1'b0, first_q} && {1'b0, gblk_q} < scan_end))
		else $error("granted block outside scan range");

	// a capture only happens on a bit that was free
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && s1_vld_q && sts.hit) |-> !word_eff[pick])
		else $error("scan picked a used block");

endmodule

@@ bench/bitmap_block_allocator_unit_test.sv @@
// Self-checking bench for bitmap_block_allocator_unit: directed edge cases, random
// request traffic over several volume settings and an output stall that backs up the input.
// Depends on bba_pkg, bba_if and the allocator RTL.
module bitmap_block_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int VOL_BLOCKS = MAX_BLOCKS_DEF;
	localparam int MAP_SIZE   = (VOL_BLOCKS < 4096) ? VOL_BLOCKS : 4096;
	localparam int COUNT_CAP  = (VOL_BLOCKS < 8191) ? VOL_BLOCKS : 8191;

	// codes the package leaves unnamed
	localparam logic [KIND_W-1:0]    KIND_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;

	typedef struct packed {
		logic [BLK_W-1:0] granted;
		logic             out_of_space;
		logic [CNT_W-1:0] free_total;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	bba_req_if req ();
	bba_rsp_if rsp ();
	bba_cfg_if cfg ();

	bitmap_block_allocator_unit #(
		.MAX_BLOCKS(VOL_BLOCKS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	// shadow of the allocator state
	bit               blk_in_use [MAP_SIZE];
	logic [CNT_W-1:0] free_tally;
	logic [BLK_W-1:0] cfg_first;
	logic [CNT_W-1:0] cfg_limit;

	alloc_result_t    pending_results [$];
	logic [BLK_W-1:0] handed_out [$];
	int               fail_count;

	// idling controls
	bit src_gaps;
	bit sink_stalls;
	int src_burst_left;
	int hold_cycles_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	function automatic alloc_result_t apply_request(logic [KIND_W-1:0] kind,
		logic [BLK_W-1:0] blk);
		alloc_result_t r;
		int scan_stop;
		r = '0;
		case (kind)
			KIND_ALLOC: begin
				scan_stop = (cfg_limit < MAP_SIZE) ? int'(cfg_limit) : MAP_SIZE;
				r.out_of_space = 1'b1;
				// first fit upward from the first data block
				for (int b = cfg_first; b < scan_stop; b++) begin
					if (!blk_in_use[b]) begin
						blk_in_use[b] = 1'b1;
						if (free_tally != 0)
							free_tally--;
						r.granted      = b[BLK_W-1:0];
						r.out_of_space = 1'b0;
						handed_out.push_back(b[BLK_W-1:0]);
						if (handed_out.size() > 64)
							void'(handed_out.pop_front());
						break;
					end
				end
			end
			KIND_FREE: begin
				// block zero and blocks past the volume are ignored
				if (blk != 0 && blk < cfg_limit && blk < MAP_SIZE) begin
					blk_in_use[blk] = 1'b0;
					if (free_tally < COUNT_CAP)
						free_tally++;
				end
			end
			KIND_MARK: begin
				if (blk < MAP_SIZE)
					blk_in_use[blk] = 1'b1;
			end
			default: ;
		endcase
		r.free_total = free_tally;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_FIRST_DATA: cfg_first = val[BLK_W-1:0];
			CFG_BLOCK_CNT:  cfg_limit = val;
			CFG_FREE_LOAD:  free_tally = (val > COUNT_CAP) ? CNT_W'(COUNT_CAP) : val;
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// one request transfer; the sender works in bursts, with random gaps when src_gaps is set
	task automatic push_req(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk);
		@(negedge clk);
		if (src_burst_left == 0) begin
			src_burst_left = $urandom_range(1, 12);
			if (src_gaps) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		src_burst_left--;
		req.valid        <= 1'b1;
		req.kind         <= kind;
		req.block_number <= blk;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(apply_request(kind, blk));
	endtask

	task automatic req_idle;
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic wait_drained;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// registers change only with the block idle
	task automatic set_volume(logic [BLK_W-1:0] first, logic [CNT_W-1:0] count,
		logic [CNT_W-1:0] load);
		req_idle();
		wait_drained();
		write_reg(CFG_FIRST_DATA, first);
		write_reg(CFG_BLOCK_CNT, count);
		write_reg(CFG_FREE_LOAD, load);
	endtask

	// ---------------------------------------------------------------- result side

	// receiver: long hold on request, else always ready or a rotating random ready pattern
	initial begin : result_sink
		logic [15:0] stall_pattern;
		int          slot;
		stall_pattern = '1;
		slot          = 0;
		rsp.ready     = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles_req != 0) begin
				rsp.ready <= 1'b0;
				for (int n = 1; n < hold_cycles_req; n++)
					@(negedge clk);
				hold_cycles_req = 0;
			end else if (!sink_stalls) begin
				rsp.ready <= 1'b1;
			end else begin
				if (slot == 0)
					stall_pattern = 16'($urandom()) | 16'h0001;
				rsp.ready <= stall_pattern[slot];
				slot = (slot + 1) % 16;
			end
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none outstanding, free_total",
					rsp.free_total, -1);
			end else begin
				want = pending_results.pop_front();
				if (rsp.granted_block !== want.granted)
					report_mismatch("granted_block", rsp.granted_block, want.granted);
				if (rsp.out_of_space !== want.out_of_space)
					report_mismatch("out_of_space", rsp.out_of_space, want.out_of_space);
				if (rsp.free_total !== want.free_total)
					report_mismatch("free_total", rsp.free_total, want.free_total);
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// reset values: first block 1, whole volume, counter at zero
	task automatic test_after_reset;
		push_req(KIND_ALLOC, 12'd0);   // counter stays at zero
		push_req(KIND_ALLOC, 12'hFFF);
		push_req(KIND_FREE, 12'd0);    // block zero is never freed
		push_req(KIND_NONE, 12'd7);
		push_req(KIND_FREE, 12'd1);
		push_req(KIND_ALLOC, 12'd0);
	endtask

	task automatic test_edges;
		// oversized load saturates; block zero grantable when first is zero
		set_volume(12'd0, 13'd4096, 13'd8191);
		write_reg(CFG_NONE, 13'h1FFF);
		push_req(KIND_ALLOC, 12'd0);
		push_req(KIND_MARK, 12'hFFF);
		push_req(KIND_FREE, 12'hFFF);
		push_req(KIND_FREE, 12'hFFF);  // already clear, counter at ceiling
		push_req(KIND_FREE, 12'd3);

		// top of the map, volume ends below it
		set_volume(12'd4090, 13'd4093, 13'd0);
		repeat (4) push_req(KIND_ALLOC, 12'd0);
		push_req(KIND_FREE, 12'd4093); // at block_count, ignored
		push_req(KIND_FREE, 12'd4092);
		push_req(KIND_ALLOC, 12'd0);

		// empty volume, first block past its end
		set_volume(12'hFFF, 13'd0, 13'd2);
		push_req(KIND_ALLOC, 12'd0);
		push_req(KIND_FREE, 12'd5);
		push_req(KIND_MARK, 12'd4094);
	endtask

	function automatic logic [BLK_W-1:0] pick_block;
		int hi;
		hi = ((cfg_limit < MAP_SIZE) ? int'(cfg_limit) : MAP_SIZE) - 1;
		if ($urandom_range(0, 9) < 7 && hi >= int'(cfg_first))
			return BLK_W'($urandom_range(hi, cfg_first));
		return BLK_W'($urandom_range(0, MAP_SIZE - 1));
	endfunction

	task automatic send_random_request;
		int r;
		int k;
		logic [BLK_W-1:0] blk;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			push_req(KIND_ALLOC, BLK_W'($urandom()));
		end else if (r < 75) begin
			// half the frees return a block that was granted, if any; the rest pick a block
			if (handed_out.size() != 0 && $urandom_range(0, 1)) begin
				k   = $urandom_range(0, handed_out.size() - 1);
				blk = handed_out[k];
				handed_out.delete(k);
			end else begin
				blk = pick_block();
			end
			push_req(KIND_FREE, blk);
		end else if (r < 92) begin
			push_req(KIND_MARK, pick_block());
		end else begin
			push_req(KIND_NONE, BLK_W'($urandom()));
		end
	endtask

	task automatic test_random_traffic;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: set_volume(12'd1, 13'd4096, CNT_W'($urandom_range(0, 4096)));
				1: set_volume(12'd0, 13'd48, CNT_W'($urandom_range(0, 64)));
				2: set_volume(12'd4064, 13'd4096, 13'd4096);
				3: set_volume(12'd1, 13'd100, 13'd0);
				4: set_volume(BLK_W'($urandom()), CNT_W'($urandom()), CNT_W'($urandom()));
				5: set_volume(12'd2000, 13'h1FFF, 13'h1FFF);
				default: set_volume(BLK_W'($urandom_range(0, 300)),
					CNT_W'($urandom_range(200, 600)), CNT_W'($urandom()));
			endcase
			src_gaps    = (p % 3 != 1);
			sink_stalls = (p % 3 != 2);
			repeat (280) send_random_request();
		end
	endtask

	// receiver holds off while the sender keeps offering; input must stall
	task automatic test_output_backpressure;
		set_volume(12'd1, 13'd512, 13'd300);
		src_gaps        = 1'b0;
		hold_cycles_req = 300;
		repeat (12) send_random_request();
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.kind         = KIND_ALLOC;
		req.block_number = '0;
		cfg.valid        = 1'b0;
		cfg.index        = CFG_FIRST_DATA;
		cfg.data         = '0;
		fail_count       = 0;
		src_gaps         = 1'b1;
		sink_stalls      = 1'b1;
		src_burst_left   = 0;
		hold_cycles_req  = 0;
		free_tally       = '0;
		cfg_first        = 12'd1;
		cfg_limit        = 13'd4096;
		foreach (blk_in_use[i])
			blk_in_use[i] = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_edges();
		test_random_traffic();
		test_output_backpressure();

		req_idle();
		wait_drained();
		repeat (140) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/bba_pkg.sv
hdl/bba_if.sv
hdl/bba_ctrl.sv
hdl/bba_datapath.sv
hdl/bitmap_block_allocator_unit.sv
bench/bitmap_block_allocator_unit_test.sv
